>>> rtl/egbr_pkg.sv
package egbr_pkg;

   localparam int MAX_BANDS      = 8;
   localparam int VERTEX_BITS    = 32;
   localparam int COUNT_BITS     = 32;
   localparam int NUM_BOUNDS     = MAX_BANDS - 1;
   localparam int NUM_BUCKETS    = MAX_BANDS * MAX_BANDS;
   localparam int BOUND_SEL_BITS = $clog2(NUM_BOUNDS);

   // field widths fixed by the interface
   localparam int GRID_BITS      = 4;
   localparam int BAND_BITS      = 3;
   localparam int BUCKET_BITS    = 6;
   localparam int SLOT_BITS      = 32;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_SIZE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUND_FIRST = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUND_LAST  = CSR_INDEX_BITS'(NUM_BOUNDS);

   typedef struct packed {
      logic [VERTEX_BITS-1:0] tail;
      logic [VERTEX_BITS-1:0] head;
      logic                   start_round;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] edge_tail;
      logic [VERTEX_BITS-1:0] edge_head;
      logic [BAND_BITS-1:0]   row_band;
      logic [BAND_BITS-1:0]   col_band;
      logic [BUCKET_BITS-1:0] bucket;
      logic [SLOT_BITS-1:0]   slot;
      logic                   slot_overflow;
   } rsp_type;

   // grid holds the effective band count, already limited to 1..MAX_BANDS
   typedef struct packed {
      logic [GRID_BITS-1:0]                    grid;
      logic [NUM_BOUNDS-1:0][VERTEX_BITS-1:0] boundary;
   } cfg_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] tail;
      logic [VERTEX_BITS-1:0] head;
      logic                   start_round;
      logic [BAND_BITS-1:0]   row_band;
      logic [BAND_BITS-1:0]   col_band;
      logic [BUCKET_BITS-1:0] bucket;
   } stage_type;

   typedef struct packed {
      logic                   fire;
      logic                   start_round;
      logic [BUCKET_BITS-1:0] bucket;
   } slot_ctl_type;

endpackage

>>> rtl/egbr_ram.sv
module egbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/egbr_csr.sv
module egbr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [egbr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [egbr_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output egbr_pkg::cfg_type                   cfg
);
   import egbr_pkg::*;

   cfg_type                   cfg_ff;
   cfg_type                   cfg_in;
   logic [GRID_BITS-1:0]      grid_raw;
   logic [GRID_BITS-1:0]      grid_eff;
   logic [BOUND_SEL_BITS-1:0] bound_sel;

   assign csr_ready = 1'b1;
   assign grid_raw  = csr_data[GRID_BITS-1:0];
   assign bound_sel = BOUND_SEL_BITS'(csr_index - CSR_BOUND_FIRST);

   // zero reads as one band, anything above the maximum as the maximum
   always_comb begin
      if (grid_raw == '0) begin
         grid_eff = GRID_BITS'(1);
      end else if (grid_raw > GRID_BITS'(MAX_BANDS)) begin
         grid_eff = GRID_BITS'(MAX_BANDS);
      end else begin
         grid_eff = grid_raw;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index) inside
            CSR_GRID_SIZE: begin
               cfg_in.grid = grid_eff;
            end
            [CSR_BOUND_FIRST:CSR_BOUND_LAST]: begin
               cfg_in.boundary[bound_sel] = VERTEX_BITS'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid     <= GRID_BITS'(1);
         cfg_ff.boundary <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/egbr_band.sv
module egbr_band (
   input  logic [egbr_pkg::VERTEX_BITS-1:0] vertex,
   input  egbr_pkg::cfg_type                cfg,
   output logic [egbr_pkg::BAND_BITS-1:0]   band
);
   import egbr_pkg::*;

   logic [NUM_BOUNDS-1:0] reached;
   logic                  running;

   always_comb begin
      for (int k = 0; k < NUM_BOUNDS; k++) begin
         reached[k] = (vertex >= cfg.boundary[k]);
      end
   end

   // band climbs through the run of reached boundaries from the bottom, up to grid - 1
   always_comb begin
      band    = '0;
      running = 1'b1;
      for (int k = 0; k < NUM_BOUNDS; k++) begin
         if (running && reached[k] && (GRID_BITS'(k + 1) < cfg.grid)) begin
            band = BAND_BITS'(k + 1);
         end else begin
            running = 1'b0;
         end
      end
   end

endmodule

>>> rtl/egbr_slot.sv
module egbr_slot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [egbr_pkg::BUCKET_BITS-1:0]    rd_bucket,
   input  egbr_pkg::slot_ctl_type              ctl,
   output logic [egbr_pkg::COUNT_BITS-1:0]     slot_count,
   output logic                                slot_ovf
);
   import egbr_pkg::*;

   logic [COUNT_BITS-1:0]  ram_rdata;
   logic [NUM_BUCKETS-1:0] live_ff;
   logic [NUM_BUCKETS-1:0] live_in;
   logic                   wr_fire_ff;
   logic [BUCKET_BITS-1:0] wr_bucket_ff;
   logic [COUNT_BITS-1:0]  wr_data_ff;
   logic [COUNT_BITS-1:0]  cur_count;
   logic [COUNT_BITS-1:0]  next_count;
   logic                   fwd_hit;

   egbr_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BUCKETS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ctl.fire),
      .wr_addr (ctl.bucket),
      .wr_data (next_count),
      .rd_addr (rd_bucket),
      .rd_data (ram_rdata)
   );

   // the read in flight missed last cycle's write, so take that one directly
   assign fwd_hit = wr_fire_ff && (wr_bucket_ff == ctl.bucket);

   always_comb begin
      if (ctl.start_round) begin
         cur_count = '0;
      end else if (fwd_hit) begin
         cur_count = wr_data_ff;
      end else if (live_ff[ctl.bucket]) begin
         cur_count = ram_rdata;
      end else begin
         cur_count = '0;
      end
   end

   assign slot_ovf   = (cur_count == '1);
   assign next_count = slot_ovf ? cur_count : cur_count + COUNT_BITS'(1);
   assign slot_count = cur_count;

   always_comb begin
      live_in = live_ff;
      if (ctl.fire) begin
         if (ctl.start_round) begin
            live_in = '0;
         end
         live_in[ctl.bucket] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         wr_fire_ff <= 1'b0;
      end else begin
         live_ff    <= live_in;
         wr_fire_ff <= ctl.fire;
      end
   end

   always_ff @(posedge clock) begin
      wr_bucket_ff <= ctl.bucket;
      wr_data_ff   <= next_count;
   end

endmodule

>>> rtl/edge_grid_bucket_router.sv
// Routes a stream of directed edges into a grid of up to 8 x 8 buckets. The tail
// picks the row band and the head the column band by comparison with the
// programmed boundaries; each transaction returns the bucket number and the
// edge's slot from a per-bucket 32-bit counter that saturates and flags
// overflow. One edge is taken per clock until back-pressure on rsp has filled
// the three stages, which each result passes in order: the input register, the
// band/bucket stage with the counter RAM read, and the counter update into the
// output register. Counters live in a 64-entry RAM with a valid flag per bucket,
// so reset and start_round clear them at once with no sweep. Write the
// boundaries and grid_size only while no edge is in flight.
module edge_grid_bucket_router (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  egbr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output egbr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [egbr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [egbr_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import egbr_pkg::*;

   cfg_type                          cfg;
   logic                             s1_vld_ff;
   req_type                          s1_data_ff;
   logic                             s2_vld_ff;
   stage_type                        s2_data_ff;
   stage_type                        s1_stage;
   logic                             rsp_valid_ff;
   rsp_type                          rsp_data_ff;
   logic                             s2_fire;
   logic                             s1_adv;
   logic [BAND_BITS-1:0]             row_band;
   logic [BAND_BITS-1:0]             col_band;
   logic [BAND_BITS+GRID_BITS-1:0]   row_base;
   logic [BUCKET_BITS-1:0]           rd_bucket;
   slot_ctl_type                     slot_ctl;
   logic [COUNT_BITS-1:0]            slot_count;
   logic                             slot_ovf;

   egbr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   egbr_band u_row_band (
      .vertex (s1_data_ff.tail),
      .cfg    (cfg),
      .band   (row_band)
   );

   egbr_band u_col_band (
      .vertex (s1_data_ff.head),
      .cfg    (cfg),
      .band   (col_band)
   );

   assign s2_fire   = s2_vld_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_adv    = !s2_vld_ff || s2_fire;
   assign req_ready = !s1_vld_ff || s1_adv;

   assign row_base = (BAND_BITS + GRID_BITS)'(row_band) * (BAND_BITS + GRID_BITS)'(cfg.grid);

   always_comb begin
      s1_stage.tail        = s1_data_ff.tail;
      s1_stage.head        = s1_data_ff.head;
      s1_stage.start_round = s1_data_ff.start_round;
      s1_stage.row_band    = row_band;
      s1_stage.col_band    = col_band;
      s1_stage.bucket      = BUCKET_BITS'(row_base + (BAND_BITS + GRID_BITS)'(col_band));
   end

   // read for whichever edge sits in the counter stage next cycle
   assign rd_bucket = (s1_vld_ff && s1_adv) ? s1_stage.bucket : s2_data_ff.bucket;

   assign slot_ctl.fire        = s2_fire;
   assign slot_ctl.start_round = s2_data_ff.start_round;
   assign slot_ctl.bucket      = s2_data_ff.bucket;

   egbr_slot u_slot (
      .clock      (clock),
      .reset      (reset),
      .rd_bucket  (rd_bucket),
      .ctl        (slot_ctl),
      .slot_count (slot_count),
      .slot_ovf   (slot_ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s2_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv && s1_vld_ff) begin
         s2_data_ff <= s1_stage;
      end
      if (s2_fire) begin
         rsp_data_ff.edge_tail     <= s2_data_ff.tail;
         rsp_data_ff.edge_head     <= s2_data_ff.head;
         rsp_data_ff.row_band      <= s2_data_ff.row_band;
         rsp_data_ff.col_band      <= s2_data_ff.col_band;
         rsp_data_ff.bucket        <= s2_data_ff.bucket;
         rsp_data_ff.slot          <= SLOT_BITS'(slot_count);
         rsp_data_ff.slot_overflow <= slot_ovf;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      s2_fire |=> rsp_valid_ff)
      else $error("counter stage fired but no result was presented");

   a_round_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_data_ff.start_round) |=>
         (rsp_data_ff.slot == '0) && !rsp_data_ff.slot_overflow)
      else $error("first edge of a round did not get slot zero");

   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.slot_overflow) |-> (rsp_data_ff.slot == '1))
      else $error("overflow flagged on a counter below its maximum");

   a_empty_takes_input: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_ready)
      else $error("input stalled with an empty input register");

endmodule

>>> tb/sv/edge_grid_bucket_router_test.sv
`timescale 1ns / 100ps

module edge_grid_bucket_router_test;
   import egbr_pkg::*;

   localparam int RESET_CYCLES  = 6;
   localparam int DRAIN_PAUSE   = 6;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_STRETCH  = 60;
   localparam int PHASE_ITEMS   = 55;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic [2:0] {
      BOUNDS_SPREAD, BOUNDS_TIGHT, BOUNDS_SCRAMBLED, BOUNDS_ZERO, BOUNDS_TOP
   } bound_style_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // local copy of the router state
   logic [GRID_BITS-1:0]   grid_cfg;
   logic [VERTEX_BITS-1:0] bound_cfg [NUM_BOUNDS];
   logic [COUNT_BITS-1:0]  bucket_fill [NUM_BUCKETS];

   req_type       edge_backlog[$];
   rsp_type       expected_routes[$];
   idle_mode_type idle_mode  = IDLE_NONE;
   int            hold_goal  = 0;
   int            hold_count = 0;
   int            stall_cycles = 0;
   int            mismatches = 0;

   edge_grid_bucket_router dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [BAND_BITS-1:0] band_of(logic [VERTEX_BITS-1:0] v, int n);
      int b;
      b = 0;
      while (b + 1 < n && b < NUM_BOUNDS && v >= bound_cfg[b])
         b++;
      return BAND_BITS'(b);
   endfunction

   function automatic rsp_type route_edge(req_type e);
      rsp_type r;
      int      n;
      int      bkt;
      n = (grid_cfg == 0) ? 1 : ((grid_cfg > MAX_BANDS) ? MAX_BANDS : int'(grid_cfg));
      if (e.start_round) begin
         foreach (bucket_fill[i])
            bucket_fill[i] = '0;
      end
      r.edge_tail = e.tail;
      r.edge_head = e.head;
      r.row_band  = band_of(e.tail, n);
      r.col_band  = band_of(e.head, n);
      bkt         = (int'(r.row_band) * n + int'(r.col_band)) % NUM_BUCKETS;
      r.bucket    = BUCKET_BITS'(bkt);
      r.slot      = SLOT_BITS'(bucket_fill[bkt]);
      // saturated counter holds its value and flags
      r.slot_overflow = (bucket_fill[bkt] == '1);
      if (!r.slot_overflow)
         bucket_fill[bkt] = bucket_fill[bkt] + 1'b1;
      return r;
   endfunction

   function automatic bit sender_waits();
      case (idle_mode)
         IDLE_SEND: return $urandom_range(99) < 85;
         IDLE_BOTH: return $urandom_range(99) < 23;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_waits();
      case (idle_mode)
         IDLE_RECV: return $urandom_range(99) < 85;
         IDLE_BOTH: return $urandom_range(99) < 23;
         default:   return 1'b0;
      endcase
   endfunction

   // half the picks fall on or next to a boundary, where the band scan turns
   function automatic logic [VERTEX_BITS-1:0] pick_vertex();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return $urandom;
         default: return bound_cfg[$urandom_range(NUM_BOUNDS - 1)]
                         + VERTEX_BITS'($urandom_range(2)) - 1'b1;
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_SIZE) begin
         grid_cfg = value[GRID_BITS-1:0];
      end else if (idx >= CSR_BOUND_FIRST && idx <= CSR_BOUND_LAST) begin
         bound_cfg[idx - CSR_BOUND_FIRST] = value;
      end
   endtask

   // checked on the falling edge so that the queues have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (edge_backlog.size() != 0 || req_valid || expected_routes.size() != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic push_edge(logic [VERTEX_BITS-1:0] t, logic [VERTEX_BITS-1:0] h, logic s);
      edge_backlog.push_back('{tail: t, head: h, start_round: s});
   endtask

   task automatic run_phase(int count, logic [GRID_BITS-1:0] grid, bound_style_type style,
                            idle_mode_type mode, int hold);
      logic [VERTEX_BITS-1:0] b;
      wait_drained();
      csr_write(CSR_GRID_SIZE, {28'($urandom), grid});
      b = (style == BOUNDS_TIGHT) ? VERTEX_BITS'($urandom_range(32'hFFFF_FF00)) : '0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         case (style)
            BOUNDS_SPREAD:    b = b + VERTEX_BITS'($urandom_range(32'h1FFF_FFFF));
            BOUNDS_TIGHT:     b = b + VERTEX_BITS'($urandom_range(3));
            BOUNDS_SCRAMBLED: b = $urandom;
            BOUNDS_ZERO:      b = '0;
            default:          b = '1;
         endcase
         csr_write(CSR_BOUND_FIRST + CSR_INDEX_BITS'(i), b);
      end
      if ($urandom_range(1))
         csr_write(CSR_BOUND_LAST + CSR_INDEX_BITS'($urandom_range(1, 8)), $urandom);
      idle_mode = mode;
      if (hold > 0)
         hold_goal = hold_count + hold;
      for (int k = 0; k < count; k++)
         push_edge(pick_vertex(), pick_vertex(),
                   (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(24) == 0));
   endtask

   always @(posedge clock) begin : edge_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_routes.push_back(route_edge(req_data));
         if (!req_valid || req_ready) begin
            if (edge_backlog.size() != 0 && !sender_waits()) begin
               req_valid <= 1'b1;
               req_data  <= edge_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : route_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_count < hold_goal) begin
         hold_count <= hold_count + 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= !receiver_waits();
      end
   end

   always @(posedge clock) begin : route_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_routes.size() == 0) begin
            $error("unexpected transaction: bucket %0d slot %0h", rsp_data.bucket, rsp_data.slot);
            mismatches++;
         end else begin
            want = expected_routes.pop_front();
            check_field("edge_tail", want.edge_tail, rsp_data.edge_tail);
            check_field("edge_head", want.edge_head, rsp_data.edge_head);
            check_field("row_band", want.row_band, rsp_data.row_band);
            check_field("col_band", want.col_band, rsp_data.col_band);
            check_field("bucket", want.bucket, rsp_data.bucket);
            check_field("slot", want.slot, rsp_data.slot);
            check_field("slot_overflow", want.slot_overflow, rsp_data.slot_overflow);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      grid_cfg = GRID_BITS'(1);
      foreach (bound_cfg[i])
         bound_cfg[i] = '0;
      foreach (bucket_fill[i])
         bucket_fill[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: single bucket, all boundaries zero
      push_edge('0, '0, 1'b0);
      push_edge('1, '1, 1'b0);
      push_edge(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      push_edge(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);

      // full grid, every band edge hit exactly and one below
      wait_drained();
      csr_write(CSR_GRID_SIZE, 32'h0000_0008);
      for (int i = 0; i < NUM_BOUNDS; i++)
         csr_write(CSR_BOUND_FIRST + CSR_INDEX_BITS'(i), 32'd1000 * (i + 1));
      csr_write(CSR_BOUND_LAST + 1'b1, '1);
      for (int i = 0; i < NUM_BOUNDS; i++)
         push_edge(bound_cfg[i], bound_cfg[i] - 1'b1, 1'b0);
      push_edge('0, '1, 1'b0);
      push_edge('1, '0, 1'b1);

      // grid size zero behaves as one; upper data bits ignored
      wait_drained();
      csr_write(CSR_GRID_SIZE, 32'hFFFF_FFF0);
      push_edge('1, 32'd5000, 1'b0);
      push_edge('0, '1, 1'b1);

      // oversize grid clamps to eight; unordered boundaries stop the scan early
      wait_drained();
      csr_write(CSR_GRID_SIZE, 32'h0000_000F);
      csr_write(CSR_BOUND_FIRST, 32'd100);
      csr_write(CSR_BOUND_FIRST + 1'b1, 32'd50);
      csr_write(CSR_BOUND_FIRST + 2'd2, 32'd200);
      csr_write(CSR_BOUND_FIRST + 2'd3, 32'd0);
      csr_write(CSR_BOUND_FIRST + 3'd4, 32'd300);
      csr_write(CSR_BOUND_FIRST + 3'd5, 32'd7);
      csr_write(CSR_BOUND_LAST, '1);
      push_edge(32'd75, 32'd150, 1'b0);
      push_edge(32'd150, 32'd49, 1'b0);
      push_edge('1, 32'd300, 1'b0);
      push_edge(32'd250, 32'd99, 1'b0);
      push_edge(32'd150, 32'd150, 1'b0);
      push_edge(32'd150, 32'd150, 1'b0);

      run_phase(PHASE_ITEMS, GRID_BITS'(8), BOUNDS_SPREAD, IDLE_NONE, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'(8), BOUNDS_TIGHT, IDLE_SEND, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'($urandom_range(2, 7)), BOUNDS_SPREAD, IDLE_RECV, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'(1), BOUNDS_SCRAMBLED, IDLE_BOTH, 0);
      // long receiver hold with the sender pushing flat out
      run_phase(PHASE_ITEMS, GRID_BITS'(8), BOUNDS_SPREAD, IDLE_NONE, HOLD_STRETCH);
      run_phase(PHASE_ITEMS, GRID_BITS'(0), BOUNDS_SPREAD, IDLE_BOTH, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'(15), BOUNDS_SCRAMBLED, IDLE_SEND, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'(8), BOUNDS_ZERO, IDLE_RECV, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'(8), BOUNDS_TOP, IDLE_NONE, 0);
      run_phase(PHASE_ITEMS, GRID_BITS'($urandom_range(1, 15)), BOUNDS_TIGHT, IDLE_BOTH, 0);

      wait_drained();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
